### sv/sdbr_pkg.sv
// shared types, constants and helpers for the stick to d-pad button repeat block
`default_nettype none
package sdbr_pkg;

    // field widths
    localparam int ButtonW  = 24;
    localparam int AxisW    = 8;
    localparam int WordW    = 32;
    localparam int CenterW  = 8;
    localparam int ThreshW  = 7;
    localparam int CountW   = 4;
    localparam int InDataW  = ButtonW + 4 * AxisW;
    localparam int OutDataW = 5 * WordW;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegCenter = 2'd0;
    localparam logic [CfgIdxW-1:0] RegThresh = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDelay  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegReload = 2'd3;

    // register reset values
    localparam logic [CenterW-1:0] CenterRst = 8'd128;
    localparam logic [ThreshW-1:0] ThreshRst = 7'd64;
    localparam logic [CountW-1:0]  DelayRst  = 4'd10;
    localparam logic [CountW-1:0]  ReloadRst = 4'd6;

    // configuration seen by the datapath
    typedef struct packed {
        logic [CenterW-1:0] center;
        logic [ThreshW-1:0] threshold;
        logic [CountW-1:0]  delay;
        logic [CountW-1:0]  reload;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [WordW-1:0] hold_word;
        logic [WordW-1:0] repeat_word;
        logic [WordW-1:0] released_word;
        logic [WordW-1:0] pressed_word;
        logic [WordW-1:0] current_word;
    } t_result;

    // saturating counter increment
    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
        logic [CountW-1:0] r;
        r = (c == {CountW{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/stick_to_dpad_button_repeat.sv
// top level: stream ports, configuration registers, input register and datapath
// Each controller sample (24 button bits plus four 8-bit stick axes) yields one
// 160-bit result: the combined 32-bit word with stick direction flags in bits
// 24..31, its pressed and released edges, and the repeat and hold words. The
// block takes one sample per cycle while the result side accepts results; a sample
// passes through the input register, then the result register. Write
// configuration only while no sample is in flight.
`default_nettype none
module stick_to_dpad_button_repeat (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input samples
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // button_bits, left_x, left_y, right_x, right_y (lowest bit up)
    input  wire logic [sdbr_pkg::InDataW-1:0]  i_s_tdata,
    // results
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // current_word, pressed_word, released_word, repeat_word, hold_word
    output logic [sdbr_pkg::OutDataW-1:0]      o_m_tdata,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [sdbr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [sdbr_pkg::CfgDataW-1:0] i_cfg_data
);

    sdbr_pkg::t_cfg               r_cfg;
    logic                         r_in_valid;
    logic [sdbr_pkg::InDataW-1:0] r_in_data;
    logic                         r_out_valid;

    logic                         w_advance;
    logic [3:0]                   w_left_flags;
    logic [3:0]                   w_right_flags;
    logic [sdbr_pkg::WordW-1:0]   w_word;
    sdbr_pkg::t_result            w_result;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center    <= sdbr_pkg::CenterRst;
            r_cfg.threshold <= sdbr_pkg::ThreshRst;
            r_cfg.delay     <= sdbr_pkg::DelayRst;
            r_cfg.reload    <= sdbr_pkg::ReloadRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdbr_pkg::RegCenter: r_cfg.center    <= i_cfg_data;
                sdbr_pkg::RegThresh: r_cfg.threshold <= i_cfg_data[sdbr_pkg::ThreshW-1:0];
                sdbr_pkg::RegDelay:  r_cfg.delay     <= i_cfg_data[sdbr_pkg::CountW-1:0];
                sdbr_pkg::RegReload: r_cfg.reload    <= i_cfg_data[sdbr_pkg::CountW-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: move the input register into the result register
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_data <= i_s_tdata;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // stick direction flags
    sdbr_stick_dir u_left (
        .i_x     (r_in_data[31:24]),
        .i_y     (r_in_data[39:32]),
        .i_cfg   (r_cfg),
        .o_flags (w_left_flags)
    );

    sdbr_stick_dir u_right (
        .i_x     (r_in_data[47:40]),
        .i_y     (r_in_data[55:48]),
        .i_cfg   (r_cfg),
        .o_flags (w_right_flags)
    );

    assign w_word = {w_right_flags, w_left_flags, r_in_data[sdbr_pkg::ButtonW-1:0]};

    // edge detect, repeat and hold
    sdbr_repeat u_repeat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_word    (w_word),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = w_result;

endmodule
`default_nettype wire

### sv/sdbr_stick_dir.sv
// direction flags (up, right, down, left) for one analog stick
`default_nettype none
module sdbr_stick_dir (
    input  wire logic [sdbr_pkg::AxisW-1:0] i_x,
    input  wire logic [sdbr_pkg::AxisW-1:0] i_y,
    input  wire sdbr_pkg::t_cfg             i_cfg,
    output logic [3:0]                      o_flags
);

    logic signed [9:0] w_lo;
    logic signed [9:0] w_hi;
    logic signed [9:0] w_x;
    logic signed [9:0] w_y;

    // window limits, may fall outside the axis range
    assign w_lo = $signed({2'b00, i_cfg.center}) - $signed({3'b000, i_cfg.threshold});
    assign w_hi = $signed({2'b00, i_cfg.center}) + $signed({3'b000, i_cfg.threshold});
    assign w_x  = $signed({2'b00, i_x});
    assign w_y  = $signed({2'b00, i_y});

    // bit0 up, bit1 right, bit2 down, bit3 left
    assign o_flags[0] = (w_y < w_lo);
    assign o_flags[2] = (w_y > w_hi);
    assign o_flags[3] = (w_x < w_lo);
    assign o_flags[1] = (w_x > w_hi);

endmodule
`default_nettype wire

### sv/sdbr_repeat.sv
// edge detect and auto-repeat state with the result register
`default_nettype none
module sdbr_repeat (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [sdbr_pkg::WordW-1:0] i_word,
    input  wire sdbr_pkg::t_cfg             i_cfg,
    output sdbr_pkg::t_result               o_result
);

    logic [sdbr_pkg::WordW-1:0]  r_prev;
    logic [sdbr_pkg::CountW-1:0] r_rep_cnt;
    logic [sdbr_pkg::CountW-1:0] r_hold_cnt;
    sdbr_pkg::t_result           r_result;

    logic [sdbr_pkg::WordW-1:0]  n_prev;
    logic [sdbr_pkg::CountW-1:0] n_rep_cnt;
    logic [sdbr_pkg::CountW-1:0] n_hold_cnt;
    sdbr_pkg::t_result           n_result;
    logic [sdbr_pkg::CountW-1:0] w_rep_inc;
    logic [sdbr_pkg::CountW-1:0] w_hold_inc;

    // next state and result for the word in the input register
    always_comb begin
        w_rep_inc  = sdbr_pkg::sat_inc(r_rep_cnt);
        w_hold_inc = sdbr_pkg::sat_inc(r_hold_cnt);
        n_prev     = r_prev;
        n_rep_cnt  = r_rep_cnt;
        n_hold_cnt = r_hold_cnt;
        n_result.current_word  = i_word;
        n_result.pressed_word  = i_word & ~r_prev;
        n_result.released_word = ~i_word & r_prev;
        n_result.repeat_word   = i_word & ~r_prev;
        n_result.hold_word     = i_word & ~r_prev;
        if (i_word == r_prev) begin
            n_rep_cnt  = w_rep_inc;
            n_hold_cnt = w_hold_inc;
            if (w_rep_inc >= i_cfg.delay) begin
                n_result.repeat_word = i_word;
                n_rep_cnt            = i_cfg.reload;
            end
            if (w_hold_inc >= i_cfg.delay) begin
                n_result.hold_word = i_word;
                n_hold_cnt         = i_cfg.delay;
            end
        end else begin
            n_rep_cnt  = '0;
            n_hold_cnt = '0;
            n_prev     = i_word;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_rep_cnt  <= '0;
            r_hold_cnt <= '0;
        end else if (i_advance) begin
            r_prev     <= n_prev;
            r_rep_cnt  <= n_rep_cnt;
            r_hold_cnt <= n_hold_cnt;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

### sim/tb_stick_to_dpad_button_repeat.sv
// testbench for stick_to_dpad_button_repeat: controller samples checked against predicted words
`timescale 1ns / 100ps
module tb_stick_to_dpad_button_repeat;
    import sdbr_pkg::*;

    localparam int IdlePct      = 36;
    localparam int HoldOffLen   = 300;
    localparam int SettleCycles = 4;

    // one controller sample, buttons in the lowest bits
    typedef struct packed {
        logic [AxisW-1:0]   right_y;
        logic [AxisW-1:0]   right_x;
        logic [AxisW-1:0]   left_y;
        logic [AxisW-1:0]   left_x;
        logic [ButtonW-1:0] buttons;
    } t_sample;

    // predicts the word stream and checks each result transfer against it
    class dpad_word_tracker;
        localparam int FlagUp    = 0;
        localparam int FlagRight = 1;
        localparam int FlagDown  = 2;
        localparam int FlagLeft  = 3;

        typedef enum logic [1:0] {ZoneMid, ZoneLow, ZoneHigh} t_zone;

        t_cfg             cfg;
        logic [WordW-1:0] prev_word;
        logic [CountW-1:0] repeat_cnt;
        logic [CountW-1:0] hold_cnt;
        t_result          expected_words[$];
        int               errors;

        function new();
            cfg.center    = CenterRst;
            cfg.threshold = ThreshRst;
            cfg.delay     = DelayRst;
            cfg.reload    = ReloadRst;
            prev_word  = '0;
            repeat_cnt = '0;
            hold_cnt   = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                RegCenter: cfg.center    = val;
                RegThresh: cfg.threshold = val[ThreshW-1:0];
                RegDelay:  cfg.delay     = val[CountW-1:0];
                RegReload: cfg.reload    = val[CountW-1:0];
                default: ;
            endcase
        endfunction

        // window limits are signed, so a limit past either end never trips
        function t_zone axis_zone(logic [AxisW-1:0] pos);
            int lo_lim;
            int hi_lim;
            lo_lim = int'(cfg.center) - int'(cfg.threshold);
            hi_lim = int'(cfg.center) + int'(cfg.threshold);
            if (int'(pos) < lo_lim) return ZoneLow;
            if (int'(pos) > hi_lim) return ZoneHigh;
            return ZoneMid;
        endfunction

        function logic [3:0] stick_flags(logic [AxisW-1:0] x, logic [AxisW-1:0] y);
            logic [3:0] f;
            f = '0;
            case (axis_zone(y))
                ZoneLow:  f[FlagUp]   = 1'b1;
                ZoneHigh: f[FlagDown] = 1'b1;
                default: ;
            endcase
            case (axis_zone(x))
                ZoneLow:  f[FlagLeft]  = 1'b1;
                ZoneHigh: f[FlagRight] = 1'b1;
                default: ;
            endcase
            return f;
        endfunction

        function void note_sample(t_sample s);
            t_result          r;
            logic [WordW-1:0] cur;
            // right stick flags in 31..28, left stick flags in 27..24
            cur = {stick_flags(s.right_x, s.right_y), stick_flags(s.left_x, s.left_y),
                   s.buttons};
            r.current_word  = cur;
            r.pressed_word  = cur & ~prev_word;
            r.released_word = ~cur & prev_word;
            r.repeat_word   = r.pressed_word;
            r.hold_word     = r.pressed_word;
            if (cur == prev_word) begin
                // saturating counters, repeat reloads and hold parks at the delay
                repeat_cnt = (repeat_cnt == '1) ? repeat_cnt : repeat_cnt + 1'b1;
                if (repeat_cnt >= cfg.delay) begin
                    r.repeat_word = cur;
                    repeat_cnt    = cfg.reload;
                end
                hold_cnt = (hold_cnt == '1) ? hold_cnt : hold_cnt + 1'b1;
                if (hold_cnt >= cfg.delay) begin
                    r.hold_word = cur;
                    hold_cnt    = cfg.delay;
                end
            end else begin
                repeat_cnt = '0;
                hold_cnt   = '0;
                prev_word  = cur;
            end
            expected_words.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [WordW-1:0] got, logic [WordW-1:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                report($sformatf("result with current %h and none expected", got.current_word));
                return;
            end
            want = expected_words.pop_front();
            compare_field("current_word", got.current_word, want.current_word);
            compare_field("pressed_word", got.pressed_word, want.pressed_word);
            compare_field("released_word", got.released_word, want.released_word);
            compare_field("repeat_word", got.repeat_word, want.repeat_word);
            compare_field("hold_word", got.hold_word, want.hold_word);
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [InDataW-1:0]  i_s_tdata   = '0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [OutDataW-1:0] o_m_tdata;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;

    int               idle_pct        = IdlePct;
    int               hold_off_cycles = 0;
    dpad_word_tracker tracker;

    always #2 i_clk = ~i_clk;

    stick_to_dpad_button_repeat i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_sample controller_sample(logic [ButtonW-1:0] b, logic [AxisW-1:0] lx,
                                                   logic [AxisW-1:0] ly, logic [AxisW-1:0] rx,
                                                   logic [AxisW-1:0] ry);
        t_sample s;
        s.buttons = b;
        s.left_x  = lx;
        s.left_y  = ly;
        s.right_x = rx;
        s.right_y = ry;
        return s;
    endfunction

    // axis values cluster at rest and around both window edges
    function automatic logic [AxisW-1:0] pick_axis();
        int c;
        int t;
        int v;
        c = tracker.cfg.center;
        t = tracker.cfg.threshold;
        case ($urandom_range(0, 3))
            0: v = c;
            1: v = c - t - 1 + int'($urandom_range(0, 2));
            2: v = c + t - 1 + int'($urandom_range(0, 2));
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        else if (v > 255) v = 255;
        return v[AxisW-1:0];
    endfunction

    function automatic t_sample fresh_sample();
        t_sample s;
        // occasional pure noise
        if ($urandom_range(0, 7) == 0) begin
            s = InDataW'({$urandom, $urandom});
            return s;
        end
        case ($urandom_range(0, 3))
            0: s.buttons = '0;
            1: s.buttons = 24'd1 << $urandom_range(0, ButtonW - 1);
            2: s.buttons = ButtonW'($urandom & $urandom);
            default: s.buttons = ButtonW'($urandom);
        endcase
        s.left_x  = pick_axis();
        s.left_y  = pick_axis();
        s.right_x = pick_axis();
        s.right_y = pick_axis();
        return s;
    endfunction

    // flip one button or jitter one axis a little
    function automatic t_sample nudge(t_sample s);
        t_sample n;
        n = s;
        case ($urandom_range(0, 4))
            0: n.buttons = n.buttons ^ (24'd1 << $urandom_range(0, ButtonW - 1));
            1: n.left_x  += 8'($urandom_range(0, 6) - 3);
            2: n.left_y  += 8'($urandom_range(0, 6) - 3);
            3: n.right_x += 8'($urandom_range(0, 6) - 3);
            default: n.right_y += 8'($urandom_range(0, 6) - 3);
        endcase
        return n;
    endfunction

    // offer one sample after a random gap and wait for its transfer
    task automatic send_sample(t_sample s);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_sample(s);
    endtask

    // runs of steady words so the repeat and hold counters get to fire
    task automatic send_runs(int count);
        t_sample s;
        int      run_len;
        int      sent;
        sent = 0;
        while (sent < count) begin
            s = fresh_sample();
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
                if (sent < count) begin
                    if ($urandom_range(0, 3) == 0) s = nudge(s);
                    send_sample(s);
                    sent++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_words.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    // unused upper data bits carry junk to show they are dropped
    task automatic write_settings(logic [CenterW-1:0] center, logic [ThreshW-1:0] thresh,
                                  logic [CountW-1:0] delay, logic [CountW-1:0] reload,
                                  logic [3:0] junk);
        put_reg(RegCenter, center);
        put_reg(RegThresh, {junk[0], thresh});
        put_reg(RegDelay, {junk, delay});
        put_reg(RegReload, {junk, reload});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: checks each transfer, idles at random, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (o_m_tvalid && i_m_tready) tracker.check_result(t_result'(o_m_tdata));
            if (hold_off_cycles != 0) begin
                hold_left = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
            @(posedge i_clk);
        end
    end

    // main sequence
    initial begin
        t_sample steady;
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples at reset settings: extremes and window edges
        send_sample(controller_sample(24'h000000, 8'd0, 8'd0, 8'd0, 8'd0));
        send_sample(controller_sample(24'hFFFFFF, 8'd255, 8'd255, 8'd255, 8'd255));
        send_sample(controller_sample(24'h000000, 8'd128, 8'd128, 8'd128, 8'd128));
        send_sample(controller_sample(24'h000000, 8'd63, 8'd63, 8'd63, 8'd63));
        send_sample(controller_sample(24'h000000, 8'd64, 8'd64, 8'd64, 8'd64));
        send_sample(controller_sample(24'h000000, 8'd192, 8'd192, 8'd192, 8'd192));
        send_sample(controller_sample(24'h000000, 8'd193, 8'd193, 8'd193, 8'd193));
        // held word long enough for repeat and hold to fire
        steady = controller_sample(24'hA5A5A5, 8'd0, 8'd255, 8'd255, 8'd0);
        repeat (15) send_sample(steady);
        send_sample(controller_sample(24'h000000, 8'd128, 8'd128, 8'd128, 8'd128));
        wait_idle();

        // narrowest window, short delay
        write_settings(8'd0, 7'd0, 4'd1, 4'd0, 4'h0);
        send_runs(200);
        wait_idle();

        // widest window, longest delay, receiver holds off to back up the input
        write_settings(8'd255, 7'd127, 4'd15, 4'd14, 4'hF);
        hold_off_cycles = HoldOffLen;
        send_runs(200);
        wait_idle();

        // zero delay and full reload, no idling on either side
        write_settings(8'd0, 7'd127, 4'd0, 4'd15, 4'h5);
        idle_pct = 0;
        send_runs(200);
        wait_idle();
        idle_pct = IdlePct;

        write_settings(8'd255, 7'd0, 4'd3, 4'd2, 4'hA);
        send_runs(200);
        wait_idle();

        // random settings
        repeat (3) begin
            write_settings(CenterW'($urandom_range(0, 255)), ThreshW'($urandom_range(0, 127)),
                           CountW'($urandom_range(1, 15)), CountW'($urandom_range(0, 14)),
                           4'($urandom_range(0, 15)));
            send_runs(180);
            wait_idle();
        end

        if (tracker.errors == 0) begin
            $display("tb_stick_to_dpad_button_repeat: PASS");
        end else begin
            $display("tb_stick_to_dpad_button_repeat: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_stick_to_dpad_button_repeat: FAIL");
        $finish;
    end

endmodule
